// File: rtl/core/doubly_linked_process_queue_macros.svh
// Assertion macros shared by the doubly linked process queue RTL.
// Holds nothing but macro definitions; included by files that assert.
`ifndef DOUBLY_LINKED_PROCESS_QUEUE_MACROS_SVH
`define DOUBLY_LINKED_PROCESS_QUEUE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DLPQ_ASSERT_HOLD(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define DLPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dlpq_pkg.sv
// Package for the doubly linked process queue: field widths, operation
// codes and the command and response word types. No dependencies.
package dlpq_pkg;

  localparam int DLPQ_ID_W      = 6;
  localparam int DLPQ_CNT_W     = 7;
  localparam int DLPQ_ID_LIMIT  = 2 ** DLPQ_ID_W;
  localparam int DLPQ_MAX_PROCS = 64;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_DEQ    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_PEEK   = 2'd3
  } dlpq_func_t;

  typedef struct packed {
    dlpq_func_t             func;
    logic [DLPQ_ID_W-1:0]   proc_id;
  } dlpq_cmd_t;

  typedef struct packed {
    logic [DLPQ_ID_W-1:0]   result_id;
    logic                   found;
    logic                   error;
    logic [DLPQ_CNT_W-1:0]  count;
  } dlpq_rsp_t;

endpackage

// File: rtl/core/dlpq_ram.sv
// Generic single write port RAM with one registered read port, read-first.
// Depends on dlpq_pkg for default sizes.
module dlpq_ram
  import dlpq_pkg::*;
#(
  parameter int WIDTH = DLPQ_ID_W,
  parameter int DEPTH = DLPQ_MAX_PROCS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/doubly_linked_process_queue.sv
// Doubly linked process queue: FIFO of slot ids with removal from anywhere.
// Result: a taken start is registered as item_valid, and the strobe done is registered from item_valid.
// Throughput: one word per cycle outside reset, bounded by the single read port of each link table.
// busy is high only while rst is high; the receiver cannot stall results.
// Synchronous reset empties the queue; link tables need no clear.
// Depends on dlpq_pkg, dlpq_ram and doubly_linked_process_queue_macros.svh.
`include "doubly_linked_process_queue_macros.svh"

module doubly_linked_process_queue
  import dlpq_pkg::*;
#(
  parameter int MAX_PROCS = DLPQ_MAX_PROCS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dlpq_cmd_t cmd,
  output logic      done,
  output dlpq_rsp_t rsp
);

  // Ids are six bits wide, so no more than 64 slots can ever be used.
  localparam int SLOTS = (MAX_PROCS < DLPQ_ID_LIMIT) ? MAX_PROCS : DLPQ_ID_LIMIT;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [DLPQ_CNT_W-1:0] SLOT_LIMIT = DLPQ_CNT_W'(SLOTS);

  typedef logic [AW-1:0]        addr_t;
  typedef logic [DLPQ_ID_W-1:0] id_t;

  // Stage one: the accepted word and the link table address it read.
  logic      item_valid;
  dlpq_cmd_t item;
  addr_t     rd_addr;

  // Queue state.
  id_t                   head, head_next;
  id_t                   tail, tail_next;
  logic [DLPQ_CNT_W-1:0] qcount, qcount_next;
  logic [SLOTS-1:0]      member, member_next;

  // Link table ports.
  logic  nwr_en, pwr_en;
  addr_t nwr_addr, pwr_addr;
  id_t   nwr_data, pwr_data;
  id_t   n_rdata, p_rdata;
  addr_t rd_addr_next;

  // The tables are read at the edge that registers the word, before it executes, so the write made
  // by the word ahead of it at that same edge is caught by these bypasses.
  logic  nbyp_en, pbyp_en;
  addr_t nbyp_addr, pbyp_addr;
  id_t   nbyp_data, pbyp_data;
  id_t   nx, pv;

  logic      id_ok, id_member;
  id_t       uid;
  dlpq_rsp_t rsp_next;

  // No word is taken while the block is held in reset.
  assign busy = rst;

  dlpq_ram #(.WIDTH(DLPQ_ID_W), .DEPTH(SLOTS)) u_next_link (
    .clk   (clk),
    .we    (nwr_en),
    .waddr (nwr_addr),
    .wdata (nwr_data),
    .raddr (rd_addr_next),
    .rdata (n_rdata)
  );

  dlpq_ram #(.WIDTH(DLPQ_ID_W), .DEPTH(SLOTS)) u_prev_link (
    .clk   (clk),
    .we    (pwr_en),
    .waddr (pwr_addr),
    .wdata (pwr_data),
    .raddr (rd_addr_next),
    .rdata (p_rdata)
  );

  assign nx = (nbyp_en && (nbyp_addr == rd_addr)) ? nbyp_data : n_rdata;
  assign pv = (pbyp_en && (pbyp_addr == rd_addr)) ? pbyp_data : p_rdata;

  assign id_ok     = {1'b0, item.proc_id} < SLOT_LIMIT;
  assign id_member = id_ok && member[AW'(item.proc_id)];

  // A dequeue unlinks the head; a removal unlinks the given id.
  assign uid = (item.func == FUNC_DEQ) ? head : item.proc_id;

  // A dequeue reads the links of whatever will be the head once the word
  // ahead of it has executed; a removal reads the links of its own id.
  assign rd_addr_next = (cmd.func == FUNC_DEQ) ? AW'(head_next) : AW'(cmd.proc_id);

  // Only links that are later read are written: the prev link of the head and
  // the next link of the tail are never used, so they are left as they are.
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    qcount_next = qcount;
    member_next = member;
    nwr_en      = 1'b0;
    nwr_addr    = AW'(tail);
    nwr_data    = item.proc_id;
    pwr_en      = 1'b0;
    pwr_addr    = AW'(item.proc_id);
    pwr_data    = tail;
    rsp_next    = '0;

    if (item_valid) begin
      unique case (item.func)
        FUNC_ENQ: begin
          if (!id_ok || id_member) begin
            rsp_next.error = 1'b1;
          end else begin
            if (qcount == '0) begin
              head_next = item.proc_id;
            end else begin
              // Hang the new id behind the current tail.
              nwr_en = 1'b1;
              pwr_en = 1'b1;
            end
            tail_next                     = item.proc_id;
            member_next[AW'(item.proc_id)] = 1'b1;
            qcount_next                   = qcount + 1'b1;
          end
        end
        FUNC_DEQ, FUNC_REMOVE: begin
          if (item.func == FUNC_REMOVE && !id_member) begin
            rsp_next.error = 1'b1;
          end else if (item.func == FUNC_REMOVE || qcount != '0) begin
            if (item.func == FUNC_DEQ) begin
              rsp_next.result_id = head;
              rsp_next.found     = 1'b1;
            end
            priority if (uid == head && uid == tail) begin
              head_next = '0;
              tail_next = '0;
            end else if (uid == head) begin
              head_next = nx;
            end else if (uid == tail) begin
              tail_next = pv;
            end else begin
              // Splice the neighbors of a middle entry together.
              nwr_en   = 1'b1;
              nwr_addr = AW'(pv);
              nwr_data = nx;
              pwr_en   = 1'b1;
              pwr_addr = AW'(nx);
              pwr_data = pv;
            end
            member_next[AW'(uid)] = 1'b0;
            qcount_next           = qcount - 1'b1;
            if (qcount_next == '0) begin
              head_next = '0;
              tail_next = '0;
            end
          end
        end
        FUNC_PEEK: begin
          if (qcount != '0) begin
            rsp_next.result_id = head;
            rsp_next.found     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    rsp_next.count = qcount_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      head       <= '0;
      tail       <= '0;
      qcount     <= '0;
      member     <= '0;
      nbyp_en    <= 1'b0;
      pbyp_en    <= 1'b0;
      done       <= 1'b0;
    end else begin
      item_valid <= start && !busy;
      head       <= head_next;
      tail       <= tail_next;
      qcount     <= qcount_next;
      member     <= member_next;
      nbyp_en    <= nwr_en;
      pbyp_en    <= pwr_en;
      done       <= item_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item      <= cmd;
    rd_addr   <= rd_addr_next;
    nbyp_addr <= nwr_addr;
    nbyp_data <= nwr_data;
    pbyp_addr <= pwr_addr;
    pbyp_data <= pwr_data;
    if (item_valid) begin
      rsp <= rsp_next;
    end
  end

  `DLPQ_ASSERT_NEXT(a_result_follows, clk, rst, item_valid, done, "word executed without result")
  `DLPQ_ASSERT_HOLD(a_count_members, clk, rst, $countones(member) == int'(qcount),
                    "queue count differs from member bits")
  `DLPQ_ASSERT_HOLD(a_empty_pointers, clk, rst, (qcount != '0) || (head == '0 && tail == '0),
                    "empty queue with nonzero head or tail")
  `DLPQ_ASSERT_HOLD(a_count_limit, clk, rst, qcount <= SLOT_LIMIT, "queue count above slot count")
  `DLPQ_ASSERT_HOLD(a_found_error, clk, rst, !done || !(rsp.found && rsp.error),
                    "result flags both found and error")

endmodule
